// ----- hdl/mavgs_pkg.sv -----
// Shared types and constants for the moving-average block with set statistics.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package mavgs_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int FRAC_W     = 8;
    localparam int WSIZE_W    = 5;
    localparam int WINDOW_MAX = 16;
    localparam int RING_AW    = 4;
    localparam int COUNT_W    = 16;
    localparam int WTOTAL_W   = 12;
    localparam int RTOTAL_W   = 24;
    localparam int WSUM_W     = 28;
    localparam int DIVIDEND_W = 36;
    localparam int DIVISOR_W  = 20;
    localparam int QUOT_W     = 16;
    localparam int FIXED_W    = 16;

    localparam logic [WSIZE_W-1:0]  WINDOW_RESET = 5'd3;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = 16'hFFFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_ONES  = 8'hFF;

    typedef enum logic [2:0] {
        DIV_FVAL,
        DIV_RAW,
        DIV_FMIN,
        DIV_FMAX,
        DIV_FMEAN
    } div_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SUM,
        ST_WUPD,
        ST_DIV_FVAL,
        ST_OUT_FVAL,
        ST_DIV_RAW,
        ST_DIV_FMIN,
        ST_DIV_FMAX,
        ST_DIV_FMEAN,
        ST_OUT_SUM
    } state_t;

    typedef struct packed {
        logic    accept;
        logic    sum_clear;
        logic    sum_step;
        logic    window_update;
        logic    div_start;
        div_op_t div_op;
        logic    out_load;
        logic    out_summary;
        logic    clear_set;
    } cmd_t;

    typedef struct packed {
        logic window_full;
        logic last;
        logic sum_done;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ----- hdl/mavgs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mavgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/mavgs_divider.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Depends on mavgs_pkg for operand widths.
`default_nettype none

module mavgs_divider
    import mavgs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic      [QUOT_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvsr_reg, dvsr_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign ge      = shifted >= {1'b0, dvsr_reg};
    assign diff    = shifted - {1'b0, dvsr_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvsr_next = divisor;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
            rem_next = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[QUOT_W-1:0];

endmodule

`default_nettype wire

// ----- hdl/mavgs_datapath.sv -----
// Datapath: sample ring, set accumulators, shared divider and result register.
// Depends on mavgs_pkg, mavgs_ram and mavgs_divider.
`default_nettype none

module mavgs_datapath
    import mavgs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cmd_t                 cmd,
    output status_t                   status,
    input  wire logic                 cfg_wr_en,
    input  wire logic [WSIZE_W-1:0]   cfg_wr_data,
    input  wire logic [SAMPLE_W-1:0]  s_sample,
    input  wire logic                 s_last_sample,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_kind,
    output logic      [FIXED_W-1:0]   m_filtered_value,
    output logic      [SAMPLE_W-1:0]  m_raw_minimum,
    output logic      [SAMPLE_W-1:0]  m_raw_maximum,
    output logic      [FIXED_W-1:0]   m_raw_mean,
    output logic                      m_filtered_valid,
    output logic      [FIXED_W-1:0]   m_filtered_minimum,
    output logic      [FIXED_W-1:0]   m_filtered_maximum,
    output logic      [FIXED_W-1:0]   m_filtered_mean,
    output logic      [COUNT_W-1:0]   m_sample_total,
    output logic                      m_end_of_run
);

    localparam int IDX_W = $clog2(WINDOW_MAX + 1);

    function automatic logic [WSIZE_W-1:0] effective_window(input logic [WSIZE_W-1:0] w);
        logic [WSIZE_W-1:0] r;
        if (w == '0) begin
            r = WSIZE_W'(1);
        end else if (w > WSIZE_W'(WINDOW_MAX)) begin
            r = WSIZE_W'(WINDOW_MAX);
        end else begin
            r = w;
        end
        return r;
    endfunction

    // set state
    logic [WSIZE_W-1:0]  window_size_reg, window_size_next;
    logic [WSIZE_W-1:0]  active_window_reg, active_window_next;
    logic [RING_AW-1:0]  ring_pointer_reg, ring_pointer_next;
    logic [COUNT_W-1:0]  seen_count_reg, seen_count_next;
    logic [RTOTAL_W-1:0] raw_total_reg, raw_total_next;
    logic [SAMPLE_W-1:0] raw_low_reg, raw_low_next;
    logic [SAMPLE_W-1:0] raw_high_reg, raw_high_next;
    logic [WTOTAL_W-1:0] window_total_reg, window_total_next;
    logic [WSUM_W-1:0]   window_sum_reg, window_sum_next;
    logic [WTOTAL_W-1:0] window_low_reg, window_low_next;
    logic [WTOTAL_W-1:0] window_high_reg, window_high_next;
    logic                saturated_reg, saturated_next;
    logic                last_reg, last_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                rd_pend_reg, rd_pend_next;
    div_op_t             div_op_reg, div_op_next;
    logic [DIVISOR_W-1:0] mean_div_reg;

    // quotients
    logic [QUOT_W-1:0] fval_reg, fval_next;
    logic [QUOT_W-1:0] raw_mean_reg, raw_mean_next;
    logic [QUOT_W-1:0] fmin_reg, fmin_next;
    logic [QUOT_W-1:0] fmax_reg, fmax_next;
    logic [QUOT_W-1:0] fmean_reg, fmean_next;

    // result register
    logic                m_valid_reg, m_valid_next;
    logic                kind_reg, kind_next;
    logic [FIXED_W-1:0]  fvalue_o_reg, fvalue_o_next;
    logic [SAMPLE_W-1:0] rmin_o_reg, rmin_o_next;
    logic [SAMPLE_W-1:0] rmax_o_reg, rmax_o_next;
    logic [FIXED_W-1:0]  rmean_o_reg, rmean_o_next;
    logic                fvalid_o_reg, fvalid_o_next;
    logic [FIXED_W-1:0]  fmin_o_reg, fmin_o_next;
    logic [FIXED_W-1:0]  fmax_o_reg, fmax_o_next;
    logic [FIXED_W-1:0]  fmean_o_reg, fmean_o_next;
    logic [COUNT_W-1:0]  total_o_reg, total_o_next;
    logic                eor_o_reg, eor_o_next;

    logic                  window_full;
    logic                  out_free;
    logic                  rd_en;
    logic [RING_AW-1:0]    rd_addr;
    logic [SAMPLE_W-1:0]   rd_data;
    logic [COUNT_W-1:0]    averages;
    logic [DIVISOR_W:0]    mean_prod;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_done;
    logic [QUOT_W-1:0]     div_quotient;

    assign window_full = seen_count_reg >= COUNT_W'(active_window_reg);
    assign out_free    = !m_valid_reg || m_ready;

    assign status.window_full = window_full;
    assign status.last        = last_reg;
    assign status.sum_done    = (idx_reg == IDX_W'(active_window_reg)) && !rd_pend_reg;
    assign status.div_done    = div_done;
    assign status.out_free    = out_free;

    assign rd_en   = cmd.sum_step && (idx_reg < IDX_W'(active_window_reg));
    assign rd_addr = ring_pointer_reg - RING_AW'(1) - idx_reg[RING_AW-1:0];

    mavgs_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (cmd.accept),
        .wr_addr (ring_pointer_reg),
        .wr_data (s_sample),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign averages  = seen_count_reg - COUNT_W'(active_window_reg) + COUNT_W'(1);
    assign mean_prod = (DIVISOR_W + 1)'(active_window_reg) * (DIVISOR_W + 1)'(averages);

    always_ff @(posedge aclk) begin
        mean_div_reg <= mean_prod[DIVISOR_W-1:0];
    end

    always_comb begin
        unique case (cmd.div_op)
            DIV_FVAL: begin
                div_dividend = DIVIDEND_W'({window_total_reg, {FRAC_W{1'b0}}});
                div_divisor  = DIVISOR_W'(active_window_reg);
            end
            DIV_RAW: begin
                div_dividend = DIVIDEND_W'({raw_total_reg, {FRAC_W{1'b0}}});
                div_divisor  = DIVISOR_W'(seen_count_reg);
            end
            DIV_FMIN: begin
                div_dividend = DIVIDEND_W'({window_low_reg, {FRAC_W{1'b0}}});
                div_divisor  = DIVISOR_W'(active_window_reg);
            end
            DIV_FMAX: begin
                div_dividend = DIVIDEND_W'({window_high_reg, {FRAC_W{1'b0}}});
                div_divisor  = DIVISOR_W'(active_window_reg);
            end
            DIV_FMEAN: begin
                div_dividend = {window_sum_reg, {FRAC_W{1'b0}}};
                div_divisor  = mean_div_reg;
            end
            default: begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    mavgs_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        window_size_next   = cfg_wr_en ? cfg_wr_data : window_size_reg;
        active_window_next = active_window_reg;
        ring_pointer_next  = ring_pointer_reg;
        seen_count_next    = seen_count_reg;
        raw_total_next     = raw_total_reg;
        raw_low_next       = raw_low_reg;
        raw_high_next      = raw_high_reg;
        window_total_next  = window_total_reg;
        window_sum_next    = window_sum_reg;
        window_low_next    = window_low_reg;
        window_high_next   = window_high_reg;
        saturated_next     = saturated_reg;
        last_next          = last_reg;
        idx_next           = idx_reg;
        rd_pend_next       = rd_pend_reg;
        div_op_next        = div_op_reg;
        fval_next          = fval_reg;
        raw_mean_next      = raw_mean_reg;
        fmin_next          = fmin_reg;
        fmax_next          = fmax_reg;
        fmean_next         = fmean_reg;

        if (cmd.accept) begin
            if (seen_count_reg == '0) begin
                active_window_next = effective_window(window_size_reg);
            end
            ring_pointer_next = ring_pointer_reg + RING_AW'(1);
            saturated_next    = seen_count_reg == COUNT_MAX;
            if (seen_count_reg != COUNT_MAX) begin
                seen_count_next = seen_count_reg + COUNT_W'(1);
                raw_total_next  = raw_total_reg + RTOTAL_W'(s_sample);
            end
            if (s_sample < raw_low_reg) begin
                raw_low_next = s_sample;
            end
            if (s_sample > raw_high_reg) begin
                raw_high_next = s_sample;
            end
            last_next = s_last_sample;
        end

        if (cmd.sum_clear) begin
            window_total_next = '0;
            idx_next          = '0;
            rd_pend_next      = 1'b0;
        end else if (cmd.sum_step) begin
            if (rd_pend_reg) begin
                window_total_next = window_total_reg + WTOTAL_W'(rd_data);
            end
            rd_pend_next = rd_en;
            if (rd_en) begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end

        if (cmd.window_update) begin
            if (!saturated_reg) begin
                window_sum_next = window_sum_reg + WSUM_W'(window_total_reg);
            end
            if (window_total_reg < window_low_reg) begin
                window_low_next = window_total_reg;
            end
            if (window_total_reg > window_high_reg) begin
                window_high_next = window_total_reg;
            end
        end

        if (cmd.div_start) begin
            div_op_next = cmd.div_op;
        end

        // store the quotient of the finished division under its operation
        if (div_done) begin
            unique case (div_op_reg)
                DIV_FVAL:  fval_next     = div_quotient;
                DIV_RAW:   raw_mean_next = div_quotient;
                DIV_FMIN:  fmin_next     = div_quotient;
                DIV_FMAX:  fmax_next     = div_quotient;
                DIV_FMEAN: fmean_next    = div_quotient;
                default:   fval_next     = fval_reg;
            endcase
        end

        if (cmd.clear_set) begin
            ring_pointer_next = '0;
            window_total_next = '0;
            seen_count_next   = '0;
            raw_total_next    = '0;
            raw_low_next      = SAMPLE_ONES;
            raw_high_next     = '0;
            window_sum_next   = '0;
            window_low_next   = '1;
            window_high_next  = '0;
        end
    end

    always_comb begin
        m_valid_next  = m_valid_reg && !m_ready;
        kind_next     = kind_reg;
        fvalue_o_next = fvalue_o_reg;
        rmin_o_next   = rmin_o_reg;
        rmax_o_next   = rmax_o_reg;
        rmean_o_next  = rmean_o_reg;
        fvalid_o_next = fvalid_o_reg;
        fmin_o_next   = fmin_o_reg;
        fmax_o_next   = fmax_o_reg;
        fmean_o_next  = fmean_o_reg;
        total_o_next  = total_o_reg;
        eor_o_next    = eor_o_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            if (cmd.out_summary) begin
                kind_next     = 1'b1;
                fvalue_o_next = '0;
                rmin_o_next   = raw_low_reg;
                rmax_o_next   = raw_high_reg;
                rmean_o_next  = raw_mean_reg;
                fvalid_o_next = window_full;
                fmin_o_next   = window_full ? fmin_reg : '0;
                fmax_o_next   = window_full ? fmax_reg : '0;
                fmean_o_next  = window_full ? fmean_reg : '0;
                total_o_next  = seen_count_reg;
                eor_o_next    = 1'b1;
            end else begin
                kind_next     = 1'b0;
                fvalue_o_next = fval_reg;
                rmin_o_next   = '0;
                rmax_o_next   = '0;
                rmean_o_next  = '0;
                fvalid_o_next = 1'b0;
                fmin_o_next   = '0;
                fmax_o_next   = '0;
                fmean_o_next  = '0;
                total_o_next  = '0;
                eor_o_next    = !last_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg   <= WINDOW_RESET;
            active_window_reg <= WINDOW_RESET;
            ring_pointer_reg  <= '0;
            seen_count_reg    <= '0;
            raw_total_reg     <= '0;
            raw_low_reg       <= SAMPLE_ONES;
            raw_high_reg      <= '0;
            window_total_reg  <= '0;
            window_sum_reg    <= '0;
            window_low_reg    <= '1;
            window_high_reg   <= '0;
            saturated_reg     <= 1'b0;
            last_reg          <= 1'b0;
            idx_reg           <= '0;
            rd_pend_reg       <= 1'b0;
            div_op_reg        <= DIV_FVAL;
            m_valid_reg       <= 1'b0;
        end else begin
            window_size_reg   <= window_size_next;
            active_window_reg <= active_window_next;
            ring_pointer_reg  <= ring_pointer_next;
            seen_count_reg    <= seen_count_next;
            raw_total_reg     <= raw_total_next;
            raw_low_reg       <= raw_low_next;
            raw_high_reg      <= raw_high_next;
            window_total_reg  <= window_total_next;
            window_sum_reg    <= window_sum_next;
            window_low_reg    <= window_low_next;
            window_high_reg   <= window_high_next;
            saturated_reg     <= saturated_next;
            last_reg          <= last_next;
            idx_reg           <= idx_next;
            rd_pend_reg       <= rd_pend_next;
            div_op_reg        <= div_op_next;
            m_valid_reg       <= m_valid_next;
        end
        fval_reg     <= fval_next;
        raw_mean_reg <= raw_mean_next;
        fmin_reg     <= fmin_next;
        fmax_reg     <= fmax_next;
        fmean_reg    <= fmean_next;
        kind_reg     <= kind_next;
        fvalue_o_reg <= fvalue_o_next;
        rmin_o_reg   <= rmin_o_next;
        rmax_o_reg   <= rmax_o_next;
        rmean_o_reg  <= rmean_o_next;
        fvalid_o_reg <= fvalid_o_next;
        fmin_o_reg   <= fmin_o_next;
        fmax_o_reg   <= fmax_o_next;
        fmean_o_reg  <= fmean_o_next;
        total_o_reg  <= total_o_next;
        eor_o_reg    <= eor_o_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_kind             = kind_reg;
    assign m_filtered_value   = fvalue_o_reg;
    assign m_raw_minimum      = rmin_o_reg;
    assign m_raw_maximum      = rmax_o_reg;
    assign m_raw_mean         = rmean_o_reg;
    assign m_filtered_valid   = fvalid_o_reg;
    assign m_filtered_minimum = fmin_o_reg;
    assign m_filtered_maximum = fmax_o_reg;
    assign m_filtered_mean    = fmean_o_reg;
    assign m_sample_total     = total_o_reg;
    assign m_end_of_run       = eor_o_reg;

endmodule

`default_nettype wire

// ----- hdl/mavgs_ctrl.sv -----
// Controller state machine: sequences accept, window sum, divisions and output.
// Depends on mavgs_pkg for the state, command and status types.
`default_nettype none

module mavgs_ctrl
    import mavgs_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next        = state_reg;
        s_ready           = 1'b0;
        cmd.accept        = 1'b0;
        cmd.sum_clear     = 1'b0;
        cmd.sum_step      = 1'b0;
        cmd.window_update = 1'b0;
        cmd.div_start     = 1'b0;
        cmd.div_op        = DIV_FVAL;
        cmd.out_load      = 1'b0;
        cmd.out_summary   = 1'b0;
        cmd.clear_set     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                priority if (status.window_full) begin
                    cmd.sum_clear = 1'b1;
                    state_next    = ST_SUM;
                end else if (status.last) begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = DIV_RAW;
                    state_next    = ST_DIV_RAW;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SUM: begin
                cmd.sum_step = 1'b1;
                if (status.sum_done) begin
                    state_next = ST_WUPD;
                end
            end
            ST_WUPD: begin
                cmd.window_update = 1'b1;
                cmd.div_start     = 1'b1;
                cmd.div_op        = DIV_FVAL;
                state_next        = ST_DIV_FVAL;
            end
            ST_DIV_FVAL: begin
                if (status.div_done) begin
                    state_next = ST_OUT_FVAL;
                end
            end
            ST_OUT_FVAL: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    if (status.last) begin
                        cmd.div_start = 1'b1;
                        cmd.div_op    = DIV_RAW;
                        state_next    = ST_DIV_RAW;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIV_RAW: begin
                if (status.div_done) begin
                    if (status.window_full) begin
                        cmd.div_start = 1'b1;
                        cmd.div_op    = DIV_FMIN;
                        state_next    = ST_DIV_FMIN;
                    end else begin
                        state_next = ST_OUT_SUM;
                    end
                end
            end
            ST_DIV_FMIN: begin
                if (status.div_done) begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = DIV_FMAX;
                    state_next    = ST_DIV_FMAX;
                end
            end
            ST_DIV_FMAX: begin
                if (status.div_done) begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = DIV_FMEAN;
                    state_next    = ST_DIV_FMEAN;
                end
            end
            ST_DIV_FMEAN: begin
                if (status.div_done) begin
                    state_next = ST_OUT_SUM;
                end
            end
            ST_OUT_SUM: begin
                if (status.out_free) begin
                    cmd.out_load    = 1'b1;
                    cmd.out_summary = 1'b1;
                    cmd.clear_set   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/moving_average_with_stats.sv -----
// Top level of the boxcar moving-average filter with per-set statistics.
// Depends on mavgs_pkg, mavgs_ctrl and mavgs_datapath.
`default_nettype none

// Boxcar moving average over 8-bit samples of one data set, the last sample
// marked by s_last_sample. Once the set holds at least window_size samples,
// every request yields one result (m_kind 0) with the average of the latest
// window samples in unsigned 8.8, truncated. After the last sample a summary
// follows (m_kind 1): raw min, max and 8.8 mean, the min, max and mean of the
// window averages (zero, with m_filtered_valid low, if the set was shorter
// than the window) and the sample count, which saturates at 65535. The set
// state is then cleared. window_size must be written through cfg_wr_en and
// cfg_wr_data only while the block is idle; the block leaves that check to
// the user. 0 acts as 1, values above 16 as 16, and the value is latched at
// the first sample of each set. Sequencing: one request is handled at a time.
// A sample that does not fill the window is only accepted and checked, unless
// it is the last of its set. A sample with a full window goes through accept,
// check, a sum of the ring through its single read port, window update, a
// division in the serial divider, which produces one quotient bit per cycle,
// and the result load. The summary adds one division (raw mean) or four (with
// filtered stats) and its own load. A finished result sits in the output
// register, so the next request is taken while it waits for m_ready.

module moving_average_with_stats
    import mavgs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration
    input  wire logic                 cfg_wr_en,
    input  wire logic [WSIZE_W-1:0]   cfg_wr_data,
    // sample requests
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [SAMPLE_W-1:0]  s_sample,
    input  wire logic                 s_last_sample,
    // results
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_kind,
    output logic      [FIXED_W-1:0]   m_filtered_value,
    output logic      [SAMPLE_W-1:0]  m_raw_minimum,
    output logic      [SAMPLE_W-1:0]  m_raw_maximum,
    output logic      [FIXED_W-1:0]   m_raw_mean,
    output logic                      m_filtered_valid,
    output logic      [FIXED_W-1:0]   m_filtered_minimum,
    output logic      [FIXED_W-1:0]   m_filtered_maximum,
    output logic      [FIXED_W-1:0]   m_filtered_mean,
    output logic      [COUNT_W-1:0]   m_sample_total,
    output logic                      m_end_of_run
);

    cmd_t    cmd;
    status_t status;

    // sequence each request: accept, window sum, divisions, result load
    mavgs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // hold the ring, set accumulators, shared divider and result register
    mavgs_datapath u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_sample           (s_sample),
        .s_last_sample      (s_last_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_kind             (m_kind),
        .m_filtered_value   (m_filtered_value),
        .m_raw_minimum      (m_raw_minimum),
        .m_raw_maximum      (m_raw_maximum),
        .m_raw_mean         (m_raw_mean),
        .m_filtered_valid   (m_filtered_valid),
        .m_filtered_minimum (m_filtered_minimum),
        .m_filtered_maximum (m_filtered_maximum),
        .m_filtered_mean    (m_filtered_mean),
        .m_sample_total     (m_sample_total),
        .m_end_of_run       (m_end_of_run)
    );

endmodule

`default_nettype wire

// ----- test/moving_average_with_stats_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for moving_average_with_stats: sample requests in,
// boxcar averages and per-set summaries out, checked against an in-bench model.
// Depends on mavgs_pkg and the moving_average_with_stats RTL only.

module moving_average_with_stats_tb
    import mavgs_pkg::*;
();

    // Cover the slowest correct run several times over: about 400 requests at
    // a worst-case request length each, plus the long hold-off.
    localparam int CYCLE_LIMIT   = 2_000_000;
    // A request that fills no window is only accepted and checked, so a short
    // pause after the last result shows the block idle before a register write.
    localparam int SETTLE_CYCLES = 16;
    // Longest single request: full window of 16 plus four summary divisions.
    localparam int TAIL_CYCLES   = 250;

    localparam logic KIND_AVERAGE = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [FIXED_W-1:0]  fval;
        logic [SAMPLE_W-1:0] rmin;
        logic [SAMPLE_W-1:0] rmax;
        logic [FIXED_W-1:0]  rmean;
        logic                fvalid;
        logic [FIXED_W-1:0]  fmin;
        logic [FIXED_W-1:0]  fmax;
        logic [FIXED_W-1:0]  fmean;
        logic [COUNT_W-1:0]  total;
        logic                eor;
    } stat_result_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [WSIZE_W-1:0]  cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    logic [SAMPLE_W-1:0] s_sample;
    logic                s_last_sample;
    logic                m_valid;
    logic                m_ready;
    logic                m_kind;
    logic [FIXED_W-1:0]  m_filtered_value;
    logic [SAMPLE_W-1:0] m_raw_minimum;
    logic [SAMPLE_W-1:0] m_raw_maximum;
    logic [FIXED_W-1:0]  m_raw_mean;
    logic                m_filtered_valid;
    logic [FIXED_W-1:0]  m_filtered_minimum;
    logic [FIXED_W-1:0]  m_filtered_maximum;
    logic [FIXED_W-1:0]  m_filtered_mean;
    logic [COUNT_W-1:0]  m_sample_total;
    logic                m_end_of_run;

    moving_average_with_stats dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_sample           (s_sample),
        .s_last_sample      (s_last_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_kind             (m_kind),
        .m_filtered_value   (m_filtered_value),
        .m_raw_minimum      (m_raw_minimum),
        .m_raw_maximum      (m_raw_maximum),
        .m_raw_mean         (m_raw_mean),
        .m_filtered_valid   (m_filtered_valid),
        .m_filtered_minimum (m_filtered_minimum),
        .m_filtered_maximum (m_filtered_maximum),
        .m_filtered_mean    (m_filtered_mean),
        .m_sample_total     (m_sample_total),
        .m_end_of_run       (m_end_of_run)
    );

    // ------------------------------------------------------------------
    // Model state: a copy of the block's set statistics and its register
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] hist [WINDOW_MAX];
    logic [RING_AW-1:0]  hist_wr;
    logic [COUNT_W-1:0]  set_count;
    logic [RTOTAL_W-1:0] raw_acc;
    logic [SAMPLE_W-1:0] raw_lo;
    logic [SAMPLE_W-1:0] raw_hi;
    logic [WSUM_W-1:0]   avg_acc;
    logic [WTOTAL_W-1:0] avg_lo;
    logic [WTOTAL_W-1:0] avg_hi;
    logic [WSIZE_W-1:0]  window_reg;  // last value written to the register
    int                  set_window;  // window latched at the first sample

    stat_result_t expected_results [$];

    int errors;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;
    int ready_hold;  // cycles left in a forced receiver hold-off

    // 0 acts as 1, anything past the ring depth as the ring depth
    function automatic int clamp_window(input logic [WSIZE_W-1:0] w);
        if (w == 0)
            return 1;
        if (w > WINDOW_MAX)
            return WINDOW_MAX;
        return int'(w);
    endfunction

    function automatic void clear_set_stats();
        for (int k = 0; k < WINDOW_MAX; k++)
            hist[k] = '0;
        hist_wr   = '0;
        set_count = '0;
        raw_acc   = '0;
        raw_lo    = SAMPLE_ONES;
        raw_hi    = '0;
        avg_acc   = '0;
        avg_lo    = '1;
        avg_hi    = '0;
    endfunction

    // Advance the model by one accepted request and queue what it must produce.
    function automatic void predict_sample(input logic [SAMPLE_W-1:0] smp,
                                           input logic last);
        stat_result_t        r;
        logic [RING_AW-1:0]  idx;
        logic [WTOTAL_W-1:0] win_sum;
        logic                saturated;
        longint unsigned     averages;
        int                  i;

        if (set_count == 0)
            set_window = clamp_window(window_reg);
        hist[hist_wr] = smp;
        hist_wr       = hist_wr + 1'b1;

        // Once the count is pinned, stop accumulating but keep the extremes.
        saturated = (set_count == COUNT_MAX);
        if (!saturated) begin
            set_count = set_count + 1'b1;
            raw_acc   = raw_acc + RTOTAL_W'(smp);
        end
        if (smp < raw_lo)
            raw_lo = smp;
        if (smp > raw_hi)
            raw_hi = smp;

        if (set_count >= set_window) begin
            win_sum = '0;
            for (i = 1; i <= set_window; i++) begin
                idx     = hist_wr - RING_AW'(i);
                win_sum = win_sum + WTOTAL_W'(hist[idx]);
            end
            if (!saturated)
                avg_acc = avg_acc + WSUM_W'(win_sum);
            if (win_sum < avg_lo)
                avg_lo = win_sum;
            if (win_sum > avg_hi)
                avg_hi = win_sum;
            r        = '0;
            r.kind   = KIND_AVERAGE;
            r.fval   = FIXED_W'((64'(win_sum) << FRAC_W) / set_window);
            r.eor    = !last;
            expected_results.insert(expected_results.size(), r);
        end

        if (last) begin
            r       = '0;
            r.kind  = KIND_SUMMARY;
            r.rmin  = raw_lo;
            r.rmax  = raw_hi;
            r.rmean = (set_count != 0) ?
                      FIXED_W'((64'(raw_acc) << FRAC_W) / set_count) : '0;
            if (set_count >= set_window) begin
                averages = 64'(set_count) - 64'(set_window) + 1;
                r.fvalid = 1'b1;
                r.fmin   = FIXED_W'((64'(avg_lo) << FRAC_W) / set_window);
                r.fmax   = FIXED_W'((64'(avg_hi) << FRAC_W) / set_window);
                r.fmean  = FIXED_W'((64'(avg_acc) << FRAC_W) /
                                    (64'(set_window) * averages));
            end
            r.total = set_count;
            r.eor   = 1'b1;
            expected_results.insert(expected_results.size(), r);
            clear_set_stats();
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle limit, receiver
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached with %0d results outstanding",
                     $time, expected_results.size());
            $display("[moving_average_with_stats] ERROR");
            $finish;
        end
    end

    // Drive m_ready at the falling edge. A requested hold-off is counted down
    // here, one cycle per edge, and overrides the random stall pattern.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (ready_hold > 0) begin
                ready_hold--;
                m_ready = 1'b0;
            end else begin
                m_ready = ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : check_results
        stat_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got kind %0d",
                         $time, m_kind);
                errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("kind",             want.kind,   m_kind);
                check_field("filtered_value",   want.fval,   m_filtered_value);
                check_field("raw_minimum",      want.rmin,   m_raw_minimum);
                check_field("raw_maximum",      want.rmax,   m_raw_maximum);
                check_field("raw_mean",         want.rmean,  m_raw_mean);
                check_field("filtered_valid",   want.fvalid, m_filtered_valid);
                check_field("filtered_minimum", want.fmin,   m_filtered_minimum);
                check_field("filtered_maximum", want.fmax,   m_filtered_maximum);
                check_field("filtered_mean",    want.fmean,  m_filtered_mean);
                check_field("sample_total",     want.total,  m_sample_total);
                check_field("end_of_run",       want.eor,    m_end_of_run);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one sample request; hold it until the block takes it, then
    // predict. Valid stays high on return so back-to-back requests need no gap.
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic last);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_sample      = smp;
        s_last_sample = last;
        do @(posedge aclk); while (!s_ready);
        predict_sample(smp, last);
    endtask

    // Drop valid, wait for every queued result, then let the block settle.
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the window register; only ever done with the block idle.
    task automatic write_window(input logic [WSIZE_W-1:0] w);
        drain();
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = w;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        cfg_wr_data = WSIZE_W'($urandom_range(0, 31));
        window_reg  = w;
    endtask

    // Lean on the extremes now and then so min/max tracking gets exercised.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        unique case ($urandom_range(0, 7))
            0:       return '0;
            1:       return SAMPLE_ONES;
            default: return SAMPLE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [WSIZE_W-1:0] pick_window();
        unique case ($urandom_range(0, 7))
            0:       return 5'd0;
            1:       return 5'd1;
            2:       return 5'd16;
            3:       return 5'd31;
            4:       return WSIZE_W'($urandom_range(0, 31));
            default: return WSIZE_W'($urandom_range(1, 16));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset window of 3, never written: extreme samples through the ring.
    task automatic test_default_window();
        send_sample(8'd0,   1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd0,   1'b1);
    endtask

    // Sets shorter than the window (summary only, filtered stats invalid),
    // a single-sample set, and a set that exactly fills its window.
    task automatic test_short_sets();
        write_window(5'd16);
        send_sample(8'd7,   1'b0);
        send_sample(8'd200, 1'b1);
        send_sample(8'd255, 1'b1);
        write_window(5'd4);
        send_sample(8'd1, 1'b0);
        send_sample(8'd2, 1'b0);
        send_sample(8'd3, 1'b0);
        send_sample(8'd4, 1'b1);
    endtask

    // Out-of-range windows: zero acts as one, 31 as the ring depth.
    task automatic test_window_clamp();
        write_window(5'd0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd0,   1'b1);
        write_window(5'd31);
        send_sample(8'd128, 1'b0);
        send_sample(8'd0,   1'b1);
    endtask

    // A write in the middle of a set must only apply from the next set.
    task automatic test_window_change_mid_set();
        write_window(5'd2);
        send_sample(8'd9,   1'b0);
        send_sample(8'd250, 1'b0);
        write_window(5'd1);
        send_sample(8'd100, 1'b0);
        send_sample(8'd3,   1'b1);
        send_sample(8'd77,  1'b1);
    endtask

    // Random sets, mostly short, some longer than the ring; the window is
    // rewritten between sets now and then.
    task automatic test_random_sets(input int idle_pct, input int stall_pct,
                                    input int n_requests);
        int sent;
        int len;
        int i;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_requests) begin
            if ($urandom_range(0, 2) == 0)
                write_window(pick_window());
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
                                              : $urandom_range(1, 16);
            for (i = 0; i < len; i++)
                send_sample(pick_sample(), i == len - 1);
            sent += len;
        end
        drain();
    endtask

    // Hold the receiver off for a long stretch while requests keep coming,
    // so the output register fills and the block stops taking samples.
    task automatic test_backpressure();
        int i;
        write_window(5'd1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        ready_hold     = 400;
        for (i = 0; i < 24; i++)
            send_sample(pick_sample(), i == 23);
        drain();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_sample       = '0;
        s_last_sample  = 1'b0;
        errors         = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        ready_hold     = 0;
        window_reg     = WINDOW_RESET;
        set_window     = int'(WINDOW_RESET);
        clear_set_stats();

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_default_window();
        test_short_sets();
        test_window_clamp();
        test_window_change_mid_set();
        drain();

        test_random_sets(0,  0,  85);
        test_random_sets(77, 0,  85);
        test_random_sets(0,  77, 85);
        test_random_sets(13, 13, 85);

        test_backpressure();

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("[moving_average_with_stats] OK");
        else
            $display("[moving_average_with_stats] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/mavgs_pkg.sv
hdl/mavgs_ram.sv
hdl/mavgs_divider.sv
hdl/mavgs_datapath.sv
hdl/mavgs_ctrl.sv
hdl/moving_average_with_stats.sv
test/moving_average_with_stats_tb.sv
